// File: rtl/bgc_pkg.sv
`default_nettype none
package bgc_pkg;

	localparam int unsigned OpW   = 2;
	localparam int unsigned TimeW = 32;
	localparam int unsigned CfgW  = 16;
	localparam int unsigned GestW = 3;
	localparam int unsigned CntW  = 8;
	localparam int unsigned IdxW  = 2;

	localparam logic [OpW-1:0] OP_POLL   = 2'd0;
	localparam logic [OpW-1:0] OP_BUTTON = 2'd1;
	localparam logic [OpW-1:0] OP_TAP    = 2'd2;

	localparam logic [IdxW-1:0] REG_DEBOUNCE  = 2'd0;
	localparam logic [IdxW-1:0] REG_QUICK     = 2'd1;
	localparam logic [IdxW-1:0] REG_HOLD      = 2'd2;
	localparam logic [IdxW-1:0] REG_LONG_HOLD = 2'd3;

	localparam logic [GestW-1:0] G_SINGLE = 3'd0;
	localparam logic [GestW-1:0] G_DOUBLE = 3'd1;
	localparam logic [GestW-1:0] G_HOLD   = 3'd2;
	localparam logic [GestW-1:0] G_LONG   = 3'd3;
	localparam logic [GestW-1:0] G_TAP2   = 3'd4;

	localparam logic [CfgW-1:0] DEBOUNCE_RST  = 16'd10;
	localparam logic [CfgW-1:0] QUICK_RST     = 16'd500;
	localparam logic [CfgW-1:0] HOLD_RST      = 16'd1000;
	localparam logic [CfgW-1:0] LONG_HOLD_RST = 16'd2000;

	localparam logic [CntW-1:0] PRESS_MAX = 8'd255;

	typedef logic [TimeW-1:0] time_t;
	typedef logic [CfgW-1:0]  cfg_t;

endpackage
`default_nettype wire

// File: rtl/button_gesture_classifier.sv
// Button and tap-sensor gesture classifier.
// Item channel (item_valid/item_ready): one timestamped event per transaction,
// opcode poll, button edge or tap sensor, with now_ms and button_level.
// Result channel (result_valid/result_ready): gesture code, at most one per
// event; events that cause no gesture produce no transaction.
// Config port: cfg_write_en, cfg_index, cfg_data; the user must write it only
// while idle; the block does not enforce this. Each event is evaluated in the
// input register and its gesture held in the result register. Throughput: one
// event per cycle unless stalled, set by the single evaluation stage between them.
// A stalled receiver holds the result register; the input register then holds
// one more event and item_ready falls until the result is taken.
// Reset (arst_n low): timing registers return to 10/500/1000/2000 ms, all
// tracking state clears, run start is set to all ones, both channels empty.
`default_nettype none
module button_gesture_classifier
	import bgc_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              item_valid,
	output logic             item_ready,
	input  wire  [OpW-1:0]   opcode,
	input  wire  [TimeW-1:0] now_ms,
	input  wire              button_level,
	output logic             result_valid,
	input  wire              result_ready,
	output logic [GestW-1:0] gesture,
	input  wire              cfg_write_en,
	input  wire  [IdxW-1:0]  cfg_index,
	input  wire  [CfgW-1:0]  cfg_data
);

	cfg_t debounce_q, quick_q, hold_q, long_hold_q;

	time_t          button_last_edge_q, run_start_q, tap_last_time_q;
	logic [CntW-1:0] press_count_q;
	logic [1:0]     hold_phase_q;
	logic [1:0]     tap_count_q;

	logic            valid_s1;
	logic [OpW-1:0]  opcode_s1;
	time_t           now_s1;
	logic            level_s1;

	logic             advance;
	time_t            d_btn, d_tap, d_run;
	logic [2:0]       tap_inc;
	logic             emit;
	logic [GestW-1:0] gest_d;
	logic             btn_take, btn_press, tap_take, tap_far, tap_emit;
	logic             poll_act, end_run;
	logic             hold_set;

	assign advance    = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || advance;

	assign d_btn   = now_s1 - button_last_edge_q;
	assign d_tap   = now_s1 - tap_last_time_q;
	assign d_run   = now_s1 - run_start_q;
	assign tap_inc = {1'b0, tap_count_q} + 3'd1;

	always_comb begin
		emit      = 1'b0;
		gest_d    = G_SINGLE;
		btn_take  = 1'b0;
		btn_press = 1'b0;
		tap_take  = 1'b0;
		tap_far   = 1'b0;
		tap_emit  = 1'b0;
		poll_act  = 1'b0;
		end_run   = 1'b0;
		hold_set  = 1'b0;
		case (opcode_s1)
			OP_BUTTON: begin
				btn_take  = d_btn >= {16'd0, debounce_q};
				btn_press = btn_take && level_s1;
			end
			OP_TAP: begin
				tap_take = d_tap >= {16'd0, debounce_q};
				tap_far  = d_tap >= {16'd0, hold_q};
				tap_emit = tap_take && !tap_far && tap_inc >= 3'd2;
				if (tap_emit) begin
					emit   = 1'b1;
					gest_d = G_TAP2;
				end
			end
			OP_POLL: begin
				poll_act = press_count_q != '0;
				if (poll_act) begin
					if (level_s1) begin
						if (hold_phase_q == 2'd0) begin
							if (d_run >= {16'd0, hold_q}) begin
								hold_set = 1'b1;
								emit     = 1'b1;
								gest_d   = G_HOLD;
							end
						end else if (d_run >= {16'd0, long_hold_q}) begin
							end_run = 1'b1;
							emit    = 1'b1;
							gest_d  = G_LONG;
						end
					end else if (hold_phase_q != 2'd0) begin
						end_run = 1'b1;
					end else if (d_run >= {16'd0, quick_q}) begin
						end_run = 1'b1;
						if (press_count_q == 8'd1) begin
							emit   = 1'b1;
							gest_d = G_SINGLE;
						end else if (press_count_q == 8'd2) begin
							emit   = 1'b1;
							gest_d = G_DOUBLE;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RST;
			quick_q     <= QUICK_RST;
			hold_q      <= HOLD_RST;
			long_hold_q <= LONG_HOLD_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_DEBOUNCE:  debounce_q  <= cfg_data;
				REG_QUICK:     quick_q     <= cfg_data;
				REG_HOLD:      hold_q      <= cfg_data;
				REG_LONG_HOLD: long_hold_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			opcode_s1 <= opcode;
			now_s1    <= now_ms;
			level_s1  <= button_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_last_edge_q <= '0;
			run_start_q        <= '1;
			press_count_q      <= '0;
			hold_phase_q       <= 2'd0;
			tap_last_time_q    <= '0;
			tap_count_q        <= 2'd0;
		end else if (advance) begin
			if (opcode_s1 == OP_BUTTON) begin
				tap_count_q <= 2'd0;
			end
			if (btn_take) begin
				button_last_edge_q <= now_s1;
			end
			if (btn_press) begin
				if (press_count_q == '0) begin
					run_start_q <= now_s1;
				end
				if (press_count_q != PRESS_MAX) begin
					press_count_q <= press_count_q + 8'd1;
				end
			end
			if (tap_take) begin
				tap_last_time_q <= now_s1;
				if (tap_far) begin
					tap_count_q <= 2'd1;
				end else if (tap_emit) begin
					tap_count_q <= 2'd0;
				end else begin
					tap_count_q <= tap_inc[1:0];
				end
			end
			if (hold_set) begin
				hold_phase_q <= 2'd1;
			end
			if (end_run) begin
				press_count_q <= '0;
				hold_phase_q  <= 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= emit;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			gesture <= gest_d;
		end
	end

endmodule
`default_nettype wire
